/* sv/grtb_pkg.sv */
// Package with shared constants, register indexes and table generators for the tone burst core.
`timescale 1ns / 1ps
package grtb_pkg;

    // Default sizes of the datapath and tables.
    localparam int PHASE_BITS_DEF       = 32;
    localparam int SAMPLE_BITS_DEF      = 24;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int EXP_TABLE_DEPTH_DEF  = 256;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PHASE_STEP   = 3'd0;
    localparam logic [2:0] CFG_LEVEL_DB     = 3'd1;
    localparam logic [2:0] CFG_CLIP_SAMPLES = 3'd2;
    localparam logic [2:0] CFG_RAMP_SAMPLES = 3'd3;
    localparam logic [2:0] CFG_WINDOW_RATE  = 3'd4;
    localparam logic [2:0] CFG_EAR_SELECT   = 3'd5;

    // Fixed point constants, fractions are Q30 except DB_TO_LOG2_Q24, which is Q24.
    localparam longint unsigned Q_ONE       = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned LN2_Q30     = 64'd744261118;
    localparam logic [31:0]     DB_TO_LOG2_Q24 = 32'd2786635;

    // Register reset values.
    localparam logic [7:0]  LEVEL_DB_RST = 8'hA0;
    localparam logic [15:0] CLIP_RST     = 16'd14400;
    localparam logic [14:0] RAMP_RST     = 15'd2880;

    typedef logic [30:0] t_frac;

    // Sine magnitude of a Q30 angle by a truncated Taylor series in Horner form.
    function automatic t_frac sine_mag(input longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        begin
            x2 = (x * x) >> 30;
            t  = Q_ONE;
            t  = Q_ONE - ((x2 * t) >> 30) / 64'd110;
            t  = Q_ONE - ((x2 * t) >> 30) / 64'd72;
            t  = Q_ONE - ((x2 * t) >> 30) / 64'd42;
            t  = Q_ONE - ((x2 * t) >> 30) / 64'd20;
            t  = Q_ONE - ((x2 * t) >> 30) / 64'd6;
            s = (x * t) >> 30;
            if (s > Q_ONE) begin
                s = Q_ONE;
            end
            sine_mag = t_frac'(s);
        end
    endfunction

    // Half-wave magnitude table entry: the first half of the entries is the
    // rising quadrant, the second half the falling one.
    function automatic t_frac sine_entry(input int unsigned idx, input int unsigned lg);
        longint unsigned quarter;
        longint unsigned r;
        longint unsigned x;
        begin
            quarter = 64'd1 << (lg - 2);
            r = (longint'(idx) & (quarter - 64'd1)) << 2;
            x = (r * HALF_PI_Q30) >> lg;
            if (longint'(idx) >= quarter) begin
                x = HALF_PI_Q30 - x;
            end
            sine_entry = sine_mag(x);
        end
    endfunction

    // Entry j of the table of 2^-(j/depth) in Q30.
    function automatic t_frac exp_entry(input int unsigned j, input int unsigned lg);
        longint unsigned u;
        longint unsigned y;
        longint unsigned t;
        begin
            u = (longint'(j) << 30) >> lg;
            y = (u * LN2_Q30) >> 30;
            t = Q_ONE;
            t = Q_ONE - ((y * t) >> 30) / 64'd10;
            t = Q_ONE - ((y * t) >> 30) / 64'd9;
            t = Q_ONE - ((y * t) >> 30) / 64'd8;
            t = Q_ONE - ((y * t) >> 30) / 64'd7;
            t = Q_ONE - ((y * t) >> 30) / 64'd6;
            t = Q_ONE - ((y * t) >> 30) / 64'd5;
            t = Q_ONE - ((y * t) >> 30) / 64'd4;
            t = Q_ONE - ((y * t) >> 30) / 64'd3;
            t = Q_ONE - ((y * t) >> 30) / 64'd2;
            t = Q_ONE - ((y * t) >> 30);
            exp_entry = t_frac'(t);
        end
    endfunction

endpackage

/* sv/grtb_mul.sv */
// Shared 32 by 32 multiplier with a registered product.
`timescale 1ns / 1ps
module grtb_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    // One product per cycle, registered before any further use.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

/* sv/grtb_rom.sv */
// Sine magnitude and negative power of two lookup tables with registered reads.
`timescale 1ns / 1ps
module grtb_rom #(
    parameter int LOG2_SINE = 10,
    parameter int LOG2_EXP  = 8
) (
    input  logic                 i_clk,
    input  logic                 i_sine_en,
    input  logic [LOG2_SINE-2:0] i_sine_addr,
    output logic [30:0]          o_sine,
    input  logic                 i_exp_en,
    input  logic [LOG2_EXP-1:0]  i_exp_addr,
    output logic [30:0]          o_exp
);

    localparam int SINE_N = 1 << (LOG2_SINE - 1);
    localparam int EXP_N  = 1 << LOG2_EXP;

    logic [30:0] w_sine_tab [SINE_N];
    logic [30:0] w_exp_tab  [EXP_N];
    logic [30:0] r_sine;
    logic [30:0] r_exp;

    // Table contents are fixed at elaboration.
    for (genvar g = 0; g < SINE_N; g++) begin : g_sine
        assign w_sine_tab[g] = grtb_pkg::sine_entry(g, LOG2_SINE);
    end
    for (genvar g = 0; g < EXP_N; g++) begin : g_exp
        assign w_exp_tab[g] = grtb_pkg::exp_entry(g, LOG2_EXP);
    end

    // Registered reads; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_sine_en) begin
            r_sine <= w_sine_tab[i_sine_addr];
        end
        if (i_exp_en) begin
            r_exp <= w_exp_tab[i_exp_addr];
        end
    end

    assign o_sine = r_sine;
    assign o_exp  = r_exp;

endmodule

/* sv/gaussian_ramped_tone_burst_core.sv */
// Top level of the Gaussian ramped sine tone burst generator.
`timescale 1ns / 1ps
// Each accepted request is one sample tick and yields one stereo sample. A request
// with restart high starts a burst at sample zero and phase zero. An active sample
// passes the sequencer states N2, WH, WL, WX, WE, WS, AM, MW, MS, FIN and DONE before
// it reaches the output register, an idle one only DONE; the sequence is set by the
// single shared 32x32 multiplier, which forms the window exponent, the level exponent
// and the three output scalings one after another.
// The input is not ready while a sample is in work, and a finished sample may wait
// in the output register while the next request is accepted. Configuration writes
// are always ready and must only be issued while the core is idle.
module gaussian_ramped_tone_burst_core #(
    parameter int PHASE_BITS       = grtb_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS      = grtb_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = grtb_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int EXP_TABLE_DEPTH  = grtb_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [47:0]                   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_restart,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_left_sample,
    output logic signed [SAMPLE_BITS-1:0] o_right_sample,
    output logic                          o_active,
    output logic                          o_last
);

    localparam int LOG2_SINE = $clog2(SINE_TABLE_DEPTH);
    localparam int LOG2_EXP  = $clog2(EXP_TABLE_DEPTH);
    localparam logic [31:0] SAMPLE_MAX = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [63:0] ROUND_HALF = 64'd1 << 29;
    localparam logic [30:0] ONE_Q30    = 31'd1 << 30;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_N2   = 4'd1;
    localparam logic [3:0] ST_WH   = 4'd2;
    localparam logic [3:0] ST_WL   = 4'd3;
    localparam logic [3:0] ST_WX   = 4'd4;
    localparam logic [3:0] ST_WE   = 4'd5;
    localparam logic [3:0] ST_WS   = 4'd6;
    localparam logic [3:0] ST_AM   = 4'd7;
    localparam logic [3:0] ST_MW   = 4'd8;
    localparam logic [3:0] ST_MS   = 4'd9;
    localparam logic [3:0] ST_FIN  = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    // Configuration registers.
    logic [30:0] r_phase_step;
    logic [7:0]  r_level_db;
    logic [15:0] r_clip;
    logic [14:0] r_ramp;
    logic [47:0] r_window_rate;
    logic        r_ear;

    // Burst state.
    logic [PHASE_BITS-1:0] r_phase;
    logic [16:0]           r_sample_index;

    // Sequencer and datapath registers.
    logic [3:0]  r_state;
    logic [3:0]  n_state;
    logic [14:0] r_n;
    logic [29:0] r_n2;
    logic [63:0] r_x;
    logic [30:0] r_win;
    logic [4:0]  r_aip;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic        r_neg;
    logic        r_has_win;
    logic        r_act;
    logic        r_lst;

    // Output register.
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_left;
    logic [SAMPLE_BITS-1:0] r_out_right;
    logic                   r_out_active;
    logic                   r_out_last;

    logic                   w_accept;
    logic [16:0]            w_i;
    logic [PHASE_BITS-1:0]  w_pa;
    logic [47:0]            w_step;
    logic [LOG2_SINE-1:0]   w_k;
    logic                   w_active;
    logic                   w_fade_in;
    logic                   w_fade_out;
    logic [17:0]            w_n_in;
    logic [17:0]            w_n_out;
    logic [7:0]             w_lvneg;
    logic [31:0]            w_mul_a;
    logic [31:0]            w_mul_b;
    logic [63:0]            w_prod;
    logic [63:0]            w_round;
    logic                   w_exp_en;
    logic [LOG2_EXP-1:0]    w_exp_addr;
    logic [30:0]            w_sine;
    logic [30:0]            w_exp;
    logic [30:0]            w_amp;
    logic                   w_out_free;
    logic [SAMPLE_BITS-1:0] w_tone;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_out_free  = !r_out_valid || i_ready;

    // Effective index and phase of the sample, after a possible restart.
    assign w_i        = i_restart ? 17'd0 : r_sample_index;
    assign w_pa       = i_restart ? '0 : r_phase;
    assign w_step     = {17'd0, r_phase_step};
    assign w_k        = w_pa[PHASE_BITS-1 -: LOG2_SINE];
    assign w_active   = w_i < {1'b0, r_clip};
    assign w_fade_in  = w_i < {2'b0, r_ramp};
    assign w_fade_out = ({1'b0, w_i} + {3'b0, r_ramp}) >= {2'b0, r_clip};
    assign w_n_in     = {3'b0, r_ramp} - 18'd1 - {1'b0, w_i};
    assign w_n_out    = {1'b0, w_i} + {3'b0, r_ramp} - {2'b0, r_clip};
    assign w_lvneg    = r_level_db[7] ? (8'd0 - r_level_db) : 8'd0;
    assign w_amp      = w_exp >> r_aip;
    assign w_round    = w_prod + ROUND_HALF;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_N2: begin
                w_mul_a = {17'd0, r_n};
                w_mul_b = {17'd0, r_n};
            end
            ST_WH: begin
                w_mul_a = {2'd0, w_prod[29:0]};
                w_mul_b = {8'd0, r_window_rate[47:24]};
            end
            ST_WL: begin
                w_mul_a = {2'd0, r_n2};
                w_mul_b = {8'd0, r_window_rate[23:0]};
            end
            ST_WE: begin
                w_mul_a = {24'd0, w_lvneg};
                w_mul_b = grtb_pkg::DB_TO_LOG2_Q24;
            end
            ST_AM: begin
                w_mul_a = {1'b0, w_sine};
                w_mul_b = {1'b0, w_amp};
            end
            ST_MW: begin
                w_mul_a = w_prod[61:30];
                w_mul_b = {1'b0, r_win};
            end
            ST_MS: begin
                w_mul_a = w_prod[61:30];
                w_mul_b = SAMPLE_MAX;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Exponent table reads: the window in one state, the level in the next.
    always_comb begin
        w_exp_en   = 1'b0;
        w_exp_addr = r_x[23 -: LOG2_EXP];
        case (r_state)
            ST_WE: begin
                w_exp_en   = 1'b1;
                w_exp_addr = r_x[23 -: LOG2_EXP];
            end
            ST_WS: begin
                w_exp_en   = 1'b1;
                w_exp_addr = w_prod[23 -: LOG2_EXP];
            end
            default: begin
                w_exp_en   = 1'b0;
                w_exp_addr = r_x[23 -: LOG2_EXP];
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_active ? ST_N2 : ST_DONE;
                end
            end
            ST_N2:   n_state = ST_WH;
            ST_WH:   n_state = ST_WL;
            ST_WL:   n_state = ST_WX;
            ST_WX:   n_state = ST_WE;
            ST_WE:   n_state = ST_WS;
            ST_WS:   n_state = ST_AM;
            ST_AM:   n_state = ST_MW;
            ST_MW:   n_state = ST_MS;
            ST_MS:   n_state = ST_FIN;
            ST_FIN:  n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_tone = r_neg ? (SAMPLE_BITS'(0) - r_mag) : r_mag;

    // Control state: configuration, burst position, sequencer, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= '0;
            r_level_db     <= grtb_pkg::LEVEL_DB_RST;
            r_clip         <= grtb_pkg::CLIP_RST;
            r_ramp         <= grtb_pkg::RAMP_RST;
            r_window_rate  <= '0;
            r_ear          <= 1'b0;
            r_phase        <= '0;
            r_sample_index <= {1'b0, grtb_pkg::CLIP_RST};
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    grtb_pkg::CFG_PHASE_STEP:   r_phase_step  <= i_cfg_data[30:0];
                    grtb_pkg::CFG_LEVEL_DB:     r_level_db    <= i_cfg_data[7:0];
                    grtb_pkg::CFG_CLIP_SAMPLES: r_clip        <= i_cfg_data[15:0];
                    grtb_pkg::CFG_RAMP_SAMPLES: r_ramp        <= i_cfg_data[14:0];
                    grtb_pkg::CFG_WINDOW_RATE:  r_window_rate <= i_cfg_data;
                    grtb_pkg::CFG_EAR_SELECT:   r_ear         <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                if (w_active) begin
                    r_sample_index <= w_i + 17'd1;
                    r_phase        <= w_pa + w_step[PHASE_BITS-1:0];
                end else begin
                    r_sample_index <= w_i;
                    r_phase        <= w_pa;
                end
            end
            r_state <= n_state;
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act     <= w_active;
            r_lst     <= (w_i + 17'd1) == {1'b0, r_clip};
            r_neg     <= w_k[LOG2_SINE-1];
            r_has_win <= w_fade_in || w_fade_out;
            r_n       <= w_fade_in ? w_n_in[14:0] : w_n_out[14:0];
        end
        case (r_state)
            ST_WH: r_n2 <= w_prod[29:0];
            ST_WL: r_x  <= {w_prod[55:0], 8'd0};
            ST_WX: r_x  <= r_x + {16'd0, w_prod[63:16]};
            ST_WS: begin
                if (!r_has_win) begin
                    r_win <= ONE_Q30;
                end else if (r_x[63:24] >= 40'd31) begin
                    r_win <= '0;
                end else begin
                    r_win <= w_exp >> r_x[28:24];
                end
                r_aip <= w_prod[28:24];
            end
            ST_FIN: r_mag <= w_round[30 +: SAMPLE_BITS];
            default: begin
            end
        endcase
        if (r_state == ST_DONE && w_out_free) begin
            r_out_active <= r_act;
            r_out_last   <= r_act && r_lst;
            r_out_left   <= (r_act && !r_ear) ? w_tone : '0;
            r_out_right  <= (r_act && r_ear) ? w_tone : '0;
        end
    end

    grtb_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    grtb_rom #(
        .LOG2_SINE (LOG2_SINE),
        .LOG2_EXP  (LOG2_EXP)
    ) u_rom (
        .i_clk       (i_clk),
        .i_sine_en   (w_accept),
        .i_sine_addr (w_k[LOG2_SINE-2:0]),
        .o_sine      (w_sine),
        .i_exp_en    (w_exp_en),
        .i_exp_addr  (w_exp_addr),
        .o_exp       (w_exp)
    );

    assign o_valid        = r_out_valid;
    assign o_left_sample  = r_out_left;
    assign o_right_sample = r_out_right;
    assign o_active       = r_out_active;
    assign o_last         = r_out_last;

endmodule

/* sv/grtb_checker.sv */
// Port level checks of the tone burst core and the bind that attaches them.
`timescale 1ns / 1ps
module grtb_checker #(
    parameter int SAMPLE_BITS = grtb_pkg::SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [SAMPLE_BITS-1:0] o_left_sample,
    input logic [SAMPLE_BITS-1:0] o_right_sample,
    input logic                   o_active,
    input logic                   o_last
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // The final sample of a burst is always an active one.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_active)
        else $error("last flagged outside the burst");

    // Outside the burst both ears are silent.
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_active |-> o_left_sample == '0 && o_right_sample == '0)
        else $error("nonzero sample while idle");

    // The tone reaches one ear only.
    a_one_ear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_left_sample != '0 |-> o_right_sample == '0)
        else $error("tone on both ears");

    // No result is offered right after reset.
    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result valid after reset");

endmodule

bind gaussian_ramped_tone_burst_core grtb_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_grtb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_left_sample  (o_left_sample),
    .o_right_sample (o_right_sample),
    .o_active       (o_active),
    .o_last         (o_last)
);
